@@ design/mexp_pkg.sv @@
// ============================================================================
// mexp_pkg
// Shared widths, types and register map for the modular exponentiation block.
// ============================================================================
package mexp_pkg;

  // operand width
  localparam int WIDTH = 32;

  // config bus: 32-bit data unless an operand needs more
  localparam int DATA_W    = (WIDTH > 32) ? 64 : 32;
  localparam int ADDR_STEP = DATA_W / 8;
  localparam int ADDR_W    = $clog2(2 * ADDR_STEP);

  // bit count of the multiplier sweep
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam value_t ONE_VAL  = {{(WIDTH-1){1'b0}}, 1'b1};
  localparam cnt_t   CNT_LAST = CNT_W'(WIDTH - 1);

  // register indexes (selected by the top address bit)
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // request to the shared multiply-reduce unit
  typedef struct packed {
    logic   start;
    value_t a;
    value_t b;
  } mm_req_t;

endpackage

@@ design/modular_exponentiation_top.sv @@
// ============================================================================
// modular_exponentiation_top
// power = base ^ exponent mod modulus, right-to-left square-and-multiply.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ------------------------------
// in        input      in_valid / in_stall    base     (WIDTH bits)
// out       output     out_valid / out_stall  power    (WIDTH bits)
// cfg       input      APB psel/penable/...   modulus @ 0, exponent @ step
//
// Products: every modular product runs on one shared multiply-reduce unit that
// retires one multiplier bit per clock.
// An item takes one base reduction plus one square per exponent bit up to
// the highest set bit, plus one multiply per set bit; with no stall the
// next item is taken once out_valid has dropped.
// Only one item is in flight; in_stall stays high while it runs and while
// its result waits on out_stall.
// Reset: synchronous, clears the sequencer and output valid; modulus
// resets to 1 and exponent to 0.
// ============================================================================
module modular_exponentiation_top
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  value_t            base,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output value_t            power,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_RED  = 2'd1;  // base mod n (as 1*base)
  localparam logic [1:0] S_MUL  = 2'd2;  // res = res * b
  localparam logic [1:0] S_SQR  = 2'd3;  // b = b * b

  value_t     modulus;
  value_t     exponent;

  logic [1:0] state;
  logic [1:0] state_next;
  value_t     res;          // running result
  value_t     res_next;
  value_t     bv;           // running square of the base
  value_t     bv_next;
  value_t     e_rem;        // exponent bits not yet consumed
  value_t     e_next;
  logic       fin;          // item finishes this cycle

  mm_req_t    mm_req;
  logic       mm_done;
  value_t     mm_p;
  logic       in_acc;

  mexp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .modulus  (modulus),
    .exponent (exponent)
  );

  mexp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_req),
    .n    (modulus),
    .done (mm_done),
    .p    (mm_p)
  );

  assign in_stall = (state != S_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;

  // Sequencer: accept launches the first product; a done launches the next.
  always_comb begin
    state_next = state;
    res_next   = res;
    bv_next    = bv;
    e_next     = e_rem;
    fin        = 1'b0;
    mm_req     = '{start: 1'b0, a: res, b: bv};

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          mm_req     = '{start: 1'b1, a: ONE_VAL, b: base};
          res_next   = ONE_VAL;
          e_next     = exponent;
          state_next = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) begin
          bv_next = mm_p;
          if (e_rem == '0) begin
            // zero exponent: result stays 1, whatever the modulus
            fin        = 1'b1;
            state_next = S_IDLE;
          end else if (e_rem[0]) begin
            mm_req     = '{start: 1'b1, a: res, b: mm_p};
            state_next = S_MUL;
          end else begin
            mm_req     = '{start: 1'b1, a: mm_p, b: mm_p};
            state_next = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          res_next   = mm_p;
          mm_req     = '{start: 1'b1, a: bv, b: bv};
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          bv_next = mm_p;
          e_next  = e_rem >> 1;
          if (e_rem[WIDTH-1:1] == '0) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end else if (e_rem[1]) begin
            mm_req     = '{start: 1'b1, a: res, b: mm_p};
            state_next = S_MUL;
          end else begin
            mm_req     = '{start: 1'b1, a: mm_p, b: mm_p};
            state_next = S_SQR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res   <= res_next;
    bv    <= bv_next;
    e_rem <= e_next;
    if (fin) begin
      power <= res;
    end
  end

endmodule

@@ design/mexp_cfg.sv @@
// ============================================================================
// mexp_cfg
// APB-style register file holding the modulus and the exponent.
// ============================================================================
module mexp_cfg
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output value_t            modulus,
  output value_t            exponent
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= ONE_VAL;
      exponent <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODULUS:  modulus  <= pwdata[WIDTH-1:0];
        REG_EXPONENT: exponent <= pwdata[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODULUS:  prdata = DATA_W'(modulus);
      REG_EXPONENT: prdata = DATA_W'(exponent);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/mexp_mulmod.sv @@
// ============================================================================
// mexp_mulmod
// Interleaved multiply-reduce unit: p = a*b mod n, one bit of b per cycle.
// ============================================================================
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  input  value_t  n,
  output logic    done,
  output value_t  p
);

  logic           busy;
  cnt_t           cnt;
  value_t         a_r;
  value_t         b_sh;
  value_t         acc;
  value_t         acc_next;
  logic [WIDTH+1:0] addend;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] n1;
  logic [WIDTH+1:0] n2;
  logic [WIDTH+1:0] d1;
  logic [WIDTH+1:0] d2;

  // t = 2*acc + bit*a stays below 3n; subtract n or 2n in parallel
  always_comb begin
    addend = b_sh[WIDTH-1] ? {2'b00, a_r} : '0;
    t      = {1'b0, acc, 1'b0} + addend;
    n1     = {2'b00, n};
    n2     = {1'b0, n, 1'b0};
    d1     = t - n1;
    d2     = t - n2;
    if (n == '0) begin
      acc_next = t[WIDTH-1:0];          // zero modulus: wrap at WIDTH bits
    end else if (t >= n2) begin
      acc_next = d2[WIDTH-1:0];
    end else if (t >= n1) begin
      acc_next = d1[WIDTH-1:0];
    end else begin
      acc_next = t[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_LAST;
      end else if (busy) begin
        cnt <= cnt - cnt_t'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_sh <= req.b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
    end
  end

  assign p = acc;

endmodule

@@ design/mexp_checker.sv @@
// ============================================================================
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ============================================================================
module mexp_checker
  import mexp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input value_t            power
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power))
    else $error("result changed or dropped while stalled");

  // no result can appear the cycle after an item is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result one cycle after accept");

  // one item at a time: input is blocked while a result waits
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for modular_exponentiation_top.
// Keys go in through the APB port and are read back. Base items are driven
// with random gaps and the result side is stalled at random. Each accepted
// item is scored against a behavioral square-and-multiply predictor, in order.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mexp_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 270;
  // Budget: the slowest item, plus a long stall and a long gap, for each of
  // roughly 290 items, taken several times over.
  localparam int CYCLE_LIMIT  = 4_000_000;
  // Quiet cycles after the last result, to catch a stray output.
  localparam int TAIL_CYCLES  = 100;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [ADDR_W-1:0] MODULUS_ADDR  = ADDR_W'(ADDR_STEP * REG_MODULUS);
  localparam logic [ADDR_W-1:0] EXPONENT_ADDR = ADDR_W'(ADDR_STEP * REG_EXPONENT);

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  value_t            base     = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  value_t            power;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  always #(HALF_PERIOD) clk = ~clk;

  modular_exponentiation_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .base      (base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .power     (power),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor: its own copy of the key, updated on every register write
  // --------------------------------------------------------------------------
  value_t key_modulus  = ONE_VAL;
  value_t key_exponent = '0;
  value_t expected_powers[$];

  int  mismatches = 0;
  int  cycles     = 0;
  // When clear, neither side idles: back-to-back items and no stalls.
  bit  gaps_on    = 1'b0;
  int  stall_left = 0;

  // a*x mod n on a double-width product; n == 0 means 2^WIDTH, i.e. plain wrap
  function automatic value_t mod_product(value_t a, value_t x, value_t n);
    logic [2*WIDTH-1:0] prod;
    prod = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, x};
    if (n == '0) return prod[WIDTH-1:0];
    return value_t'(prod % {{WIDTH{1'b0}}, n});
  endfunction

  // Right-to-left: the result starts at 1 and only picks up set exponent bits,
  // so a zero exponent gives 1 even under modulus one.
  function automatic value_t expected_power(value_t b);
    value_t sq, acc, e;
    sq  = (key_modulus != '0) ? b % key_modulus : b;
    acc = ONE_VAL;
    e   = key_exponent;
    while (e != '0) begin
      if (e[0]) acc = mod_product(acc, sq, key_modulus);
      e  = e >> 1;
      sq = mod_product(sq, sq, key_modulus);
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, changed at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall  = 1'b0;
      stall_left = pick_gap();
    end
  end

  // Score each accepted result against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        report_mismatch("power with no item pending", 64'(power), 64'h0);
      end else begin
        value_t want;
        want = expected_powers.pop_front();
        if (power !== want) report_mismatch("power", 64'(power), 64'(want));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Item and register traffic
  // --------------------------------------------------------------------------
  // Noise on base while valid is low; expectation is queued at acceptance.
  task automatic send_base(value_t b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      base     = value_t'($urandom);
    end
    @(negedge clk);
    in_valid = 1'b1;
    base     = b;
    do @(posedge clk); while (in_stall);
    expected_powers.push_back(expected_power(b));
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read_check(logic [ADDR_W-1:0] addr, value_t want, string what);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[WIDTH-1:0] !== want) report_mismatch(what, 64'(got), 64'(want));
  endtask

  // Only called with the block idle
  task automatic program_key(value_t n, value_t e);
    apb_write(MODULUS_ADDR, DATA_W'(n));
    apb_write(EXPONENT_ADDR, DATA_W'(e));
    key_modulus  = n;
    key_exponent = e;
    apb_read_check(MODULUS_ADDR, n, "modulus readback");
    apb_read_check(EXPONENT_ADDR, e, "exponent readback");
  endtask

  // --------------------------------------------------------------------------
  // Random key and base shapes
  // --------------------------------------------------------------------------
  function automatic value_t random_modulus();
    case ($urandom_range(0, 7))
      0:       return value_t'($urandom_range(2, 255));
      1:       return '1 - value_t'($urandom_range(0, 255));
      2:       return value_t'($urandom) | {1'b1, {(WIDTH-2){1'b0}}, 1'b1};
      3:       return ONE_VAL;
      4:       return '0;                      // wraps at 2^WIDTH
      default: return value_t'($urandom) | ONE_VAL;
    endcase
  endfunction

  function automatic value_t random_exponent();
    case ($urandom_range(0, 7))
      0:       return value_t'($urandom_range(0, 3));
      1:       return value_t'($urandom_range(0, 16'hFFFF));
      2:       return '1;
      3:       return {1'b1, {(WIDTH-1){1'b0}}} | value_t'($urandom_range(0, 1));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic value_t random_base(value_t n);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return n - ONE_VAL;
      3:       return n;                       // reduces to zero
      4:       return n + value_t'($urandom_range(1, 1000));
      5:       return value_t'($urandom_range(0, 15));
      default: return value_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset key is modulus 1, exponent 0: every base must give 1.
  task automatic test_reset_key();
    apb_read_check(MODULUS_ADDR, ONE_VAL, "modulus after reset");
    apb_read_check(EXPONENT_ADDR, '0, "exponent after reset");
    send_base('0);
    send_base('1);
    settle();
  endtask

  // Modulus one with a live exponent collapses everything to 0.
  task automatic test_modulus_one();
    program_key(ONE_VAL, 32'd5);
    send_base('0);
    send_base(32'hDEAD_BEEF);
    send_base('1);
    settle();
  endtask

  // Zero modulus stands for 2^WIDTH: products just wrap.
  task automatic test_wrap_modulus();
    program_key('0, '1);
    send_base(32'd3);
    send_base('1);
    send_base(32'h8000_0000);
    settle();
    program_key('0, '0);
    send_base(32'h1234_5678);
    settle();
  endtask

  // Field extremes, exponent of one (plain reduction) and a base at the modulus.
  task automatic test_edge_operands();
    program_key('1, '1);
    send_base('0);
    send_base('1);                             // equal to modulus
    send_base(32'hFFFF_FFFE);
    settle();
    program_key(32'hFFFF_FFFB, ONE_VAL);
    send_base('1);                             // above modulus
    send_base(32'h8000_0000);
    settle();
    program_key(32'h8000_0001, '1);
    send_base(32'h7FFF_FFFF);
    send_base(32'h5555_AAAA);
    settle();
  endtask

  // Textbook key pair: encrypt with the public exponent, decrypt with the private.
  task automatic test_rsa_pairs();
    program_key(32'd3233, 32'd17);
    send_base(32'd65);
    send_base(32'd3232);
    settle();
    program_key(32'd3233, 32'd2753);
    send_base(32'd2790);
    send_base(32'd4000);
    settle();
  endtask

  // Phases of random keys; idling on in most phases, with a full drain now
  // and then in mid-phase so the sender is held until the block is empty.
  task automatic test_random_keys();
    int     sent;
    int     phase_len;
    value_t n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = random_modulus();
      program_key(n, random_exponent());
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(15, 40);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        send_base(random_base(n));
        sent++;
        if ($urandom_range(0, 24) == 0) settle();
      end
      settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gaps_on = 1'b1;
    test_reset_key();
    test_modulus_one();
    test_wrap_modulus();
    test_edge_operands();
    test_rsa_pairs();
    test_random_keys();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
